/* rtl/vna_pkg.sv */
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types, constants and helpers for the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int DEF_MAX_VERTS = 4096;
  localparam int POS_W   = 24;
  localparam int SUM_W   = 64;
  localparam int IDX_W   = 12;
  localparam int NRM_W   = 16;
  localparam int ROOT_W  = 32;
  localparam int MAG_LIM = 30;   // magnitudes are scaled below 2^MAG_LIM
  localparam int Q_W     = 15;   // quotient bits, result never exceeds 2^14
  localparam int NUM_W   = ROOT_W + Q_W - 1;
  localparam int FRAC_Q  = 14;

  localparam logic signed [NRM_W-1:0] NRM_ONE = 16'sd16384;

  // register index decoded from the config address
  localparam logic REG_SMOOTH = 1'b0;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_TRI   = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
  } entry_t;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W-1:0] s;
    s = a + b;
    if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1]) begin
      s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s;
  endfunction

  function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

/* rtl/vertex_normal_accumulator_top.sv */
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_top
// Vertex store with area-weighted face normal sums and unit normal readout.
// ----------------------------------------------------------------------------
// A triangle makes three store reads, six passes through the shared 32x32
// multiplier and three sum updates. A read runs scaling shifts, squares, a
// 32-step root and three 15-step divides; smooth mode adds a scan of every
// loaded vertex in the store. Reset clears the vertex count, sets smooth
// mode; the store itself needs no clearing.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_top
  import vna_pkg::*;
#(
  parameter int MAX_VERTS = DEF_MAX_VERTS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              func,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [IDX_W-1:0]        corner_a,
  input  logic [IDX_W-1:0]        corner_b,
  input  logic [IDX_W-1:0]        corner_c,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic signed [NRM_W-1:0] normal_z,
  output logic                    status
);

  localparam int AW    = $clog2(MAX_VERTS);
  localparam int CNT_W = $clog2(MAX_VERTS + 1);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_T_RA, ST_T_RB, ST_T_RC, ST_T_DIFF, ST_T_MUL, ST_T_URD, ST_T_UWR,
    ST_R_RD, ST_R_REF, ST_S_RD, ST_S_ACC, ST_N_MAG, ST_N_SHIFT, ST_N_SQ,
    ST_N_ROOT, ST_N_DSTART, ST_N_DIV, ST_DONE
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] j;
  logic smooth;

  logic [IDX_W-1:0] c_a, c_b, c_c, c_k;
  logic signed [POS_W-1:0] pa_x, pa_y, pa_z, pb_x, pb_y, pb_z;
  logic signed [POS_W:0] d1x, d1y, d1z, d2x, d2y, d2z;
  logic signed [SUM_W-1:0] nx, ny, nz, vx, vy, vz, prod;
  logic signed [POS_W-1:0] rx, ry, rz;
  logic [SUM_W-1:0] m0, m1, m2, m_k, s2;
  logic neg0, neg1, neg2, neg_k, miss;
  logic [2:0] step;
  logic [1:0] k;
  logic [ROOT_W-1:0] len;
  logic signed [NRM_W-1:0] qx, qy, qz, q_signed;

  logic signed [31:0] mul_a, mul_b;
  logic signed [SUM_W-1:0] mul_p;

  logic in_acc, cfg_wr;
  func_t in_func;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t mem_wdata, rdata;

  logic sq_start, sq_done, dv_start, dv_done;
  logic [ROOT_W-1:0] sq_root;
  logic [Q_W-1:0] dv_quo;
  logic [NUM_W-1:0] dv_num;

  assign in_func = func_t'(func);
  assign in_acc  = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SMOOTH) ? {31'b0, smooth} : 32'b0;

  always_comb begin
    case (k)
      2'd0:    begin c_k = c_a; m_k = m0; neg_k = neg0; end
      2'd1:    begin c_k = c_b; m_k = m1; neg_k = neg1; end
      default: begin c_k = c_c; m_k = m2; neg_k = neg2; end
    endcase
  end

  assign q_signed = neg_k ? -NRM_W'(dv_quo) : NRM_W'(dv_quo);
  assign dv_num   = NUM_W'({m_k[MAG_LIM-1:0], {FRAC_Q{1'b0}}}) + NUM_W'(len >> 1);
  assign sq_start = (state == ST_N_SQ) && (step == 3'd4);
  assign dv_start = (state == ST_N_DSTART);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_T_MUL) begin
      case (step)
        3'd0:    begin mul_a = 32'(d1y); mul_b = 32'(d2z); end
        3'd1:    begin mul_a = 32'(d1z); mul_b = 32'(d2y); end
        3'd2:    begin mul_a = 32'(d1z); mul_b = 32'(d2x); end
        3'd3:    begin mul_a = 32'(d1x); mul_b = 32'(d2z); end
        3'd4:    begin mul_a = 32'(d1x); mul_b = 32'(d2y); end
        3'd5:    begin mul_a = 32'(d1y); mul_b = 32'(d2x); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == ST_N_SQ) begin
      case (step)
        3'd0:    begin mul_a = {2'b0, m0[MAG_LIM-1:0]}; end
        3'd1:    begin mul_a = {2'b0, m1[MAG_LIM-1:0]}; end
        3'd2:    begin mul_a = {2'b0, m2[MAG_LIM-1:0]}; end
        default: begin mul_a = '0; end
      endcase
      mul_b = mul_a;
    end
  end

  assign mul_p = mul_a * mul_b;

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(count);
    mem_wdata = '{px: pos_x, py: pos_y, pz: pos_z, sx: '0, sy: '0, sz: '0};
    mem_raddr = AW'(c_a);
    case (state)
      ST_IDLE: begin
        mem_we = in_acc && in_func == FUNC_LOAD && count < CNT_W'(MAX_VERTS);
      end
      ST_T_RB: mem_raddr = AW'(c_b);
      ST_T_RC: mem_raddr = AW'(c_c);
      ST_T_URD: mem_raddr = AW'(c_k);
      ST_T_UWR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(c_k);
        mem_wdata = '{px: rdata.px, py: rdata.py, pz: rdata.pz,
                      sx: sat_add(rdata.sx, nx), sy: sat_add(rdata.sy, ny),
                      sz: sat_add(rdata.sz, nz)};
      end
      ST_S_RD: mem_raddr = AW'(j);
      default: mem_raddr = AW'(c_a);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      smooth    <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_SMOOTH) begin
        smooth <= pwdata[0];
      end
      // the done state owns out_valid while it is active
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            c_a <= corner_a;
            c_b <= corner_b;
            c_c <= corner_c;
            case (in_func)
              FUNC_CLEAR: count <= '0;
              FUNC_LOAD: begin
                if (count < CNT_W'(MAX_VERTS)) begin
                  count <= count + 1'b1;
                end
              end
              FUNC_TRI: begin
                if (CMP_W'(corner_a) < CMP_W'(count) && CMP_W'(corner_b) < CMP_W'(count)
                    && CMP_W'(corner_c) < CMP_W'(count)) begin
                  state <= ST_T_RA;
                end
              end
              default: begin
                if (CMP_W'(corner_a) < CMP_W'(count)) begin
                  miss  <= 1'b0;
                  state <= ST_R_RD;
                end else begin
                  miss  <= 1'b1;
                  qx    <= '0;
                  qy    <= '0;
                  qz    <= '0;
                  state <= ST_DONE;
                end
              end
            endcase
          end
        end
        ST_T_RA: state <= ST_T_RB;
        ST_T_RB: begin
          pa_x  <= rdata.px;
          pa_y  <= rdata.py;
          pa_z  <= rdata.pz;
          state <= ST_T_RC;
        end
        ST_T_RC: begin
          pb_x  <= rdata.px;
          pb_y  <= rdata.py;
          pb_z  <= rdata.pz;
          state <= ST_T_DIFF;
        end
        ST_T_DIFF: begin
          d1x   <= (POS_W+1)'(pa_x) - (POS_W+1)'(pb_x);
          d1y   <= (POS_W+1)'(pa_y) - (POS_W+1)'(pb_y);
          d1z   <= (POS_W+1)'(pa_z) - (POS_W+1)'(pb_z);
          d2x   <= (POS_W+1)'(pa_x) - (POS_W+1)'(rdata.px);
          d2y   <= (POS_W+1)'(pa_y) - (POS_W+1)'(rdata.py);
          d2z   <= (POS_W+1)'(pa_z) - (POS_W+1)'(rdata.pz);
          step  <= '0;
          state <= ST_T_MUL;
        end
        ST_T_MUL: begin
          // issue product for this step, fold in the previous one
          prod <= mul_p;
          step <= step + 1'b1;
          case (step)
            3'd1:    nx <= prod;
            3'd2:    nx <= nx - prod;
            3'd3:    ny <= prod;
            3'd4:    ny <= ny - prod;
            3'd5:    nz <= prod;
            3'd6: begin
              nz    <= nz - prod;
              k     <= '0;
              state <= ST_T_URD;
            end
            default: ;
          endcase
        end
        ST_T_URD: state <= ST_T_UWR;
        ST_T_UWR: begin
          k     <= k + 1'b1;
          state <= (k == 2'd2) ? ST_IDLE : ST_T_URD;
        end
        ST_R_RD: state <= ST_R_REF;
        ST_R_REF: begin
          if (smooth) begin
            rx    <= rdata.px;
            ry    <= rdata.py;
            rz    <= rdata.pz;
            vx    <= '0;
            vy    <= '0;
            vz    <= '0;
            j     <= '0;
            state <= ST_S_RD;
          end else begin
            vx    <= rdata.sx;
            vy    <= rdata.sy;
            vz    <= rdata.sz;
            state <= ST_N_MAG;
          end
        end
        ST_S_RD: state <= ST_S_ACC;
        ST_S_ACC: begin
          if (rdata.px == rx && rdata.py == ry && rdata.pz == rz) begin
            vx <= sat_add(vx, rdata.sx);
            vy <= sat_add(vy, rdata.sy);
            vz <= sat_add(vz, rdata.sz);
          end
          j     <= j + 1'b1;
          state <= ((j + 1'b1) == count) ? ST_N_MAG : ST_S_RD;
        end
        ST_N_MAG: begin
          m0    <= mag(vx);
          m1    <= mag(vy);
          m2    <= mag(vz);
          neg0  <= vx[SUM_W-1];
          neg1  <= vy[SUM_W-1];
          neg2  <= vz[SUM_W-1];
          state <= ST_N_SHIFT;
        end
        ST_N_SHIFT: begin
          if ((m0 | m1 | m2) == '0) begin
            qx    <= '0;
            qy    <= NRM_ONE;
            qz    <= '0;
            state <= ST_DONE;
          end else if ((m0[SUM_W-1:MAG_LIM] | m1[SUM_W-1:MAG_LIM] |
                        m2[SUM_W-1:MAG_LIM]) != '0) begin
            m0 <= m0 >> 1;
            m1 <= m1 >> 1;
            m2 <= m2 >> 1;
          end else begin
            step  <= '0;
            state <= ST_N_SQ;
          end
        end
        ST_N_SQ: begin
          prod <= mul_p;
          step <= step + 1'b1;
          case (step)
            3'd1:    s2 <= prod;
            3'd2:    s2 <= s2 + prod;
            3'd3:    s2 <= s2 + prod;
            3'd4:    state <= ST_N_ROOT;
            default: ;
          endcase
        end
        ST_N_ROOT: begin
          if (sq_done) begin
            len   <= sq_root;
            k     <= '0;
            state <= ST_N_DSTART;
          end
        end
        ST_N_DSTART: state <= ST_N_DIV;
        ST_N_DIV: begin
          if (dv_done) begin
            case (k)
              2'd0:    qx <= q_signed;
              2'd1:    qy <= q_signed;
              default: qz <= q_signed;
            endcase
            k     <= k + 1'b1;
            state <= (k == 2'd2) ? ST_DONE : ST_N_DSTART;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            normal_x  <= qx;
            normal_y  <= qy;
            normal_z  <= qz;
            status    <= miss;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  vna_mem #(
    .DEPTH (MAX_VERTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  vna_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (s2),
    .done  (sq_done),
    .root  (sq_root)
  );

  vna_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (len),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VERTS))
    else $error("vertex count beyond capacity");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside done state");

  a_store_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_T_UWR || (in_acc && in_func == FUNC_LOAD)))
    else $error("unexpected store write");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (normal_x <= NRM_ONE && normal_x >= -NRM_ONE &&
                   normal_y <= NRM_ONE && normal_y >= -NRM_ONE &&
                   normal_z <= NRM_ONE && normal_z >= -NRM_ONE))
    else $error("normal component out of range");

endmodule

/* rtl/vna_mem.sv */
// ----------------------------------------------------------------------------
// vna_mem
// Vertex store: position and normal sums, one write and one read port.
// ----------------------------------------------------------------------------
module vna_mem
  import vna_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_VERTS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/vna_sqrt.sv */
// ----------------------------------------------------------------------------
// vna_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module vna_sqrt
  import vna_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  x,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] res;
  logic [SUM_W-1:0] bitv;
  logic [4:0]       cnt;
  logic             run;
  logic [SUM_W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= x;
        res  <= '0;
        bitv <= {2'b01, {(SUM_W-2){1'b0}}};
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == 5'(ROOT_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/vna_div.sv */
// ----------------------------------------------------------------------------
// vna_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vna_div
  import vna_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [ROOT_W-1:0] den,
  output logic              done,
  output logic [Q_W-1:0]    quo
);

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [3:0]       cnt;
  logic             run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= num;
        dsh <= NUM_W'(den) << (Q_W - 1);
        quo <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[Q_W-2:0], 1'b1};
        end else begin
          quo <= {quo[Q_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == 4'(Q_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* tb/sv/vna_checker.sv */
// ----------------------------------------------------------------------------
// vna_checker
// Watches the config port and both channels of the vertex normal accumulator,
// keeps its own vertex store and sums, and checks every returned normal.
// ----------------------------------------------------------------------------
module vna_checker
  import vna_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  input  logic                    pready,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              func,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [IDX_W-1:0]        corner_a,
  input  logic [IDX_W-1:0]        corner_b,
  input  logic [IDX_W-1:0]        corner_c,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [NRM_W-1:0] normal_x,
  input  logic signed [NRM_W-1:0] normal_y,
  input  logic signed [NRM_W-1:0] normal_z,
  input  logic                    status,
  output int                      fail_count,
  output int                      pending,
  output int                      in_count,
  output int                      out_count
);

  localparam int NVERT = DEF_MAX_VERTS;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic                    st;
  } normal_res_t;

  logic signed [POS_W-1:0] vpx [NVERT];
  logic signed [POS_W-1:0] vpy [NVERT];
  logic signed [POS_W-1:0] vpz [NVERT];
  logic signed [SUM_W-1:0] acc_x [NVERT];
  logic signed [SUM_W-1:0] acc_y [NVERT];
  logic signed [SUM_W-1:0] acc_z [NVERT];
  int unsigned             vert_count;
  logic                    smooth_on;
  normal_res_t             expected_normals [$];

  function automatic logic signed [SUM_W-1:0] clamp_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) return s[SUM_W] ? SUM_MIN : SUM_MAX;
    return s[SUM_W-1:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] bit_v;
    logic [63:0] rem;
    r = 0;
    rem = x;
    bit_v = 64'd1 << 62;
    while (bit_v > rem) bit_v >>= 2;
    while (bit_v != 0) begin
      if (rem >= r + bit_v) begin
        rem = rem - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  function automatic normal_res_t unit_normal(
    input logic signed [SUM_W-1:0] vx,
    input logic signed [SUM_W-1:0] vy,
    input logic signed [SUM_W-1:0] vz
  );
    logic signed [SUM_W-1:0] v [3];
    logic [63:0]             m [3];
    logic [63:0]             mx, s2, len, q;
    logic [15:0]             o [3];
    int                      sh;
    normal_res_t             res;
    v[0] = vx; v[1] = vy; v[2] = vz;
    mx = 0;
    s2 = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i][SUM_W-1] ? (~v[i] + 64'd1) : v[i];
      if (m[i] > mx) mx = m[i];
    end
    res.st = 1'b0;
    if (mx == 0) begin
      res.nx = 0; res.ny = NRM_ONE; res.nz = 0;
      return res;
    end
    while ((mx >> sh) >= (64'd1 << 30)) sh++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> sh;
      s2 = s2 + m[i] * m[i];
    end
    len = int_sqrt(s2);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = (64'd16384 * m[i] + len / 2) / len;
      if (v[i][SUM_W-1]) q = ~q + 64'd1;
      o[i] = q[15:0];
    end
    res.nx = o[0]; res.ny = o[1]; res.nz = o[2];
    return res;
  endfunction

  task automatic add_face(input int unsigned a, input int unsigned b, input int unsigned c);
    logic signed [SUM_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic signed [SUM_W-1:0] d1x, d1y, d1z, d2x, d2y, d2z, fx, fy, fz;
    int unsigned             k [3];
    if (a >= vert_count || b >= vert_count || c >= vert_count) return;
    ax = vpx[a]; ay = vpy[a]; az = vpz[a];
    bx = vpx[b]; by = vpy[b]; bz = vpz[b];
    cx = vpx[c]; cy = vpy[c]; cz = vpz[c];
    d1x = ax - bx; d1y = ay - by; d1z = az - bz;
    d2x = ax - cx; d2y = ay - cy; d2z = az - cz;
    fx = d1y * d2z - d1z * d2y;
    fy = d1z * d2x - d1x * d2z;
    fz = d1x * d2y - d1y * d2x;
    k[0] = a; k[1] = b; k[2] = c;
    for (int i = 0; i < 3; i++) begin
      acc_x[k[i]] = clamp_add(acc_x[k[i]], fx);
      acc_y[k[i]] = clamp_add(acc_y[k[i]], fy);
      acc_z[k[i]] = clamp_add(acc_z[k[i]], fz);
    end
  endtask

  function automatic normal_res_t vertex_normal(input int unsigned idx);
    logic signed [SUM_W-1:0] sx, sy, sz;
    normal_res_t             res;
    if (idx >= vert_count) begin
      res.nx = 0; res.ny = 0; res.nz = 0; res.st = 1'b1;
      return res;
    end
    if (smooth_on) begin
      sx = 0; sy = 0; sz = 0;
      for (int unsigned j = 0; j < vert_count; j++) begin
        if (vpx[j] == vpx[idx] && vpy[j] == vpy[idx] && vpz[j] == vpz[idx]) begin
          sx = clamp_add(sx, acc_x[j]);
          sy = clamp_add(sy, acc_y[j]);
          sz = clamp_add(sz, acc_z[j]);
        end
      end
    end else begin
      sx = acc_x[idx]; sy = acc_y[idx]; sz = acc_z[idx];
    end
    return unit_normal(sx, sy, sz);
  endfunction

  always @(posedge clk) begin
    normal_res_t want;
    if (rst) begin
      vert_count = 0;
      smooth_on = 1'b1;
      expected_normals.delete();
      fail_count = 0;
      in_count = 0;
      out_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'd0) smooth_on = pwdata[0];
      // results first: a transaction accepted now cannot return on this edge
      if (out_valid && !out_stall) begin
        out_count++;
        if (expected_normals.size() == 0) begin
          $error("unexpected normal: x %0d y %0d z %0d status %0d",
                 normal_x, normal_y, normal_z, status);
          fail_count++;
        end else begin
          want = expected_normals.pop_front();
          if (normal_x !== want.nx) begin
            $error("normal_x: expected %0d, got %0d", want.nx, normal_x);
            fail_count++;
          end
          if (normal_y !== want.ny) begin
            $error("normal_y: expected %0d, got %0d", want.ny, normal_y);
            fail_count++;
          end
          if (normal_z !== want.nz) begin
            $error("normal_z: expected %0d, got %0d", want.nz, normal_z);
            fail_count++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_count++;
        case (func_t'(func))
          FUNC_CLEAR: vert_count = 0;
          FUNC_LOAD: begin
            if (vert_count < NVERT) begin
              vpx[vert_count] = pos_x;
              vpy[vert_count] = pos_y;
              vpz[vert_count] = pos_z;
              acc_x[vert_count] = 0;
              acc_y[vert_count] = 0;
              acc_z[vert_count] = 0;
              vert_count++;
            end
          end
          FUNC_TRI:  add_face(corner_a, corner_b, corner_c);
          FUNC_READ: begin
            want = vertex_normal(corner_a);
            expected_normals.insert(expected_normals.size(), want);
          end
          default: ;
        endcase
      end
    end
    pending = expected_normals.size();
  end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the vertex normal accumulator: directed corner cases and
// random mesh phases under both smoothing settings. Checking is done by
// vna_checker beside the block.
// ----------------------------------------------------------------------------
module tb;
  import vna_pkg::*;

  localparam logic signed [POS_W-1:0] PMAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] PMIN = 24'sh800000;

  logic                    clk;
  logic                    rst;
  logic                    psel, penable, pwrite;
  logic [2:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    in_valid, in_stall;
  logic [1:0]              func;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [IDX_W-1:0]        corner_a, corner_b, corner_c;
  logic                    out_valid, out_stall;
  logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
  logic                    status;
  int                      fail_count, pending, in_count, out_count;

  int                      burst_left;
  bit                      no_gaps;
  int unsigned             nloaded;
  logic signed [POS_W-1:0] pool [4][3];

  vertex_normal_accumulator_top i_dut (.*);

  vna_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver stall pattern: free, coin flip, sparse, or mostly held
  always @(negedge clk) begin
    static int st_left = 0;
    static int st_mode = 0;
    if (st_left == 0) begin
      st_mode = $urandom_range(0, 3);
      st_left = $urandom_range(20, 200);
    end
    st_left--;
    case (st_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= 1'($urandom_range(0, 1));
      2:       out_stall <= ($urandom_range(0, 7) == 0);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  task automatic send(input func_t f, input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                      input logic [POS_W-1:0] z, input logic [IDX_W-1:0] a,
                      input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] c);
    int gap;
    @(negedge clk);
    if (!no_gaps && burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    func <= f;
    pos_x <= x; pos_y <= y; pos_z <= z;
    corner_a <= a; corner_b <= b; corner_c <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (f == FUNC_CLEAR) nloaded = 0;
    if (f == FUNC_LOAD && nloaded < DEF_MAX_VERTS) nloaded++;
  endtask

  task automatic load_vertex(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input logic [POS_W-1:0] z);
    send(FUNC_LOAD, x, y, z, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic face(input int unsigned a, input int unsigned b, input int unsigned c);
    send(FUNC_TRI, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
         IDX_W'(a), IDX_W'(b), IDX_W'(c));
  endtask

  task automatic read_normal(input int unsigned a);
    send(FUNC_READ, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
         IDX_W'(a), IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic clear_store();
    send(FUNC_CLEAR, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
         IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
  endtask

  // drain outstanding normals, then let a triangle still in flight finish
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_smooth(input logic val);
    wait_idle();
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 3'd0;
    pwdata <= {31'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return PMAX;
      1:       return PMIN;
      2:       return 24'd0;
      3:       return POS_W'($urandom_range(0, 31) - 16);
      default: return POS_W'($urandom);
    endcase
  endfunction

  task automatic random_vertex();
    int p;
    p = $urandom_range(0, 3);
    if ($urandom_range(0, 1)) load_vertex(pool[p][0], pool[p][1], pool[p][2]);
    else load_vertex(pick_coord(), pick_coord(), pick_coord());
  endtask

  function automatic int unsigned any_corner();
    return (nloaded == 0) ? 0 : $urandom_range(0, nloaded - 1);
  endfunction

  task automatic random_phase(input int unsigned nitems);
    int unsigned nv;
    int          r;
    for (int p = 0; p < 4; p++)
      for (int k = 0; k < 3; k++) pool[p][k] = pick_coord();
    clear_store();
    nv = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(3, 16);
    repeat (nv) random_vertex();
    repeat (nitems) begin
      r = $urandom_range(0, 99);
      if (r < 45) face(any_corner(), any_corner(), any_corner());
      else if (r < 50) face(any_corner(), $urandom_range(nloaded, 4095), any_corner());
      else if (r < 85) read_normal(any_corner());
      else if (r < 90) read_normal($urandom_range(nloaded, 4095));
      else if (r < 97) random_vertex();
      else begin
        clear_store();
        repeat (3) random_vertex();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 3'd0; pwdata = 32'd0;
    in_valid = 1'b0; out_stall = 1'b0;
    func = FUNC_CLEAR;
    pos_x = 0; pos_y = 0; pos_z = 0;
    corner_a = 0; corner_b = 0; corner_c = 0;
    burst_left = 0; no_gaps = 1'b0; nloaded = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty store, zero sum, merge of equal positions, bad corners
    read_normal(0);
    face(0, 1, 2);
    load_vertex(PMAX, PMAX, PMAX);
    load_vertex(PMAX, PMIN, PMAX);
    load_vertex(PMAX, PMAX, PMIN);
    load_vertex(PMIN, PMIN, PMIN);
    load_vertex(0, 0, 0);
    load_vertex(PMAX, PMAX, PMAX);
    read_normal(0);
    face(0, 1, 2);
    face(5, 3, 4);
    face(0, 1, 9);
    face(0, 0, 1);
    read_normal(0);
    read_normal(5);
    read_normal(3);
    read_normal(4095);
    read_normal(6);
    write_smooth(1'b0);
    read_normal(0);
    read_normal(5);
    read_normal(4);
    clear_store();
    read_normal(0);
    load_vertex(-24'sd1, 24'sd1, -24'sd1);
    read_normal(0);

    // random mesh phases, smoothing set at random before each one
    for (int ph = 0; ph < 14; ph++) begin
      write_smooth(1'($urandom_range(0, 1)));
      random_phase(30);
    end

    wait_idle();
    $display("covered %0d input transactions and %0d normals, flat and smooth,",
             in_count, out_count);
    $display("including empty stores, out-of-range corners and merged positions");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #160000000;
    $display("status: fail");
    $finish;
  end

endmodule
